// File: rtl/fpst_pkg.sv
// Shared types and constants for the Fenwick prefix-sum table.
// No dependencies; imported by the controller, the datapath and the top level.
package fpst_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int POS_W         = 11;
  localparam int DELTA_W       = 32;
  localparam int SUM_W         = 64;
  // walk index: position plus one climb step, never above 2 * 2047
  localparam int IDX_W         = POS_W + 1;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

  // register word index, taken from paddr[2]
  localparam logic REG_SIZE_IN_USE = 1'b0;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic start;     // load a new word into the walk registers
    logic walk;      // advance the walk by one tree node
    logic clear_en;  // write one zero entry of the clearing pass
    logic load_out;  // copy the finished total into the output register
  } fpst_cmd_t;

  typedef struct packed {
    logic clear_last;  // clearing pass is on its last entry
    logic walk_done;   // no node left to visit and no read in flight
    logic is_query;    // word being walked is a prefix query
  } fpst_status_t;

endpackage

// File: rtl/fpst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fpst_ctrl.sv
// Controller for the Fenwick prefix-sum table: clearing pass, walk, result hand-off.
// Depends on fpst_pkg.
module fpst_ctrl
  import fpst_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  fpst_status_t status,
  output fpst_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          if (!status.is_query) begin
            state_nxt = ST_IDLE;
          end else if (slot_free) begin
            cmd.load_out  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/fpst_dp.sv
// Datapath for the Fenwick prefix-sum table: walk index, accumulator, table RAM.
// Depends on fpst_pkg and fpst_ram.
module fpst_dp
  import fpst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fpst_cmd_t               cmd,
  output fpst_status_t            status,
  input  logic [POS_W-1:0]        size_in_use,
  input  logic                    in_func,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [DELTA_W-1:0] in_delta,
  output logic signed [SUM_W-1:0] out_prefix_total
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    func_r;
  logic signed [SUM_W-1:0] delta_r;
  logic [SUM_W-1:0]        acc_r, acc_nxt;
  logic                    pend_r, pend_nxt;
  logic [AW-1:0]           prev_addr_r, prev_addr_nxt;
  logic signed [SUM_W-1:0] total_r;

  logic [IDX_W-1:0] low_bit;
  logic [IDX_W-1:0] idx_m1;
  logic [XW-1:0]    idx_m1_ext;
  logic             in_table;
  logic             active;
  logic             issue;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [SUM_W-1:0] ram_rdata;

  assign low_bit    = idx_r & (~idx_r + IDX_W'(1));
  assign idx_m1     = idx_r - IDX_W'(1);
  assign idx_m1_ext = XW'(idx_m1);
  assign in_table   = (32'(idx_r) <= 32'(TABLE_DEPTH));

  // adds stop above the bound in use or the table depth; queries run down to zero
  always_comb begin
    if (func_r == FUNC_ADD) begin
      active = (idx_r != '0) && (idx_r <= {1'b0, size_in_use}) && in_table;
    end else begin
      active = (idx_r != '0);
    end
  end

  // nodes above the table depth are skipped without a read
  assign issue = cmd.walk && active && in_table;

  always_comb begin
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    prev_addr_nxt = prev_addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    if (cmd.clear_en) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
    end
    if (cmd.start) begin
      idx_nxt  = {1'b0, in_position};
      acc_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (cmd.walk) begin
      if (pend_r && (func_r == FUNC_QUERY)) begin
        acc_nxt = acc_r + ram_rdata;
      end
      pend_nxt = issue;
      if (issue) begin
        prev_addr_nxt = idx_m1_ext[AW-1:0];
      end
      if (active) begin
        idx_nxt = (func_r == FUNC_ADD) ? idx_r + low_bit : idx_r - low_bit;
      end
    end
  end

  // node written back while the next node is read: addresses always differ
  assign ram_we    = cmd.clear_en || (cmd.walk && pend_r && (func_r == FUNC_ADD));
  assign ram_waddr = cmd.clear_en ? clr_cnt_r : prev_addr_r;
  assign ram_wdata = cmd.clear_en ? '0 : ram_rdata + delta_r;

  fpst_ram #(
    .WIDTH (SUM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (idx_m1_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      pend_r    <= 1'b0;
      idx_r     <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      pend_r    <= pend_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    prev_addr_r <= prev_addr_nxt;
    if (cmd.start) begin
      func_r  <= in_func;
      delta_r <= SUM_W'(in_delta);
    end
    if (cmd.load_out) begin
      total_r <= $signed(acc_r);
    end
  end

  assign status.clear_last = (clr_cnt_r == AW'(TABLE_DEPTH - 1));
  assign status.walk_done  = !active && !pend_r;
  assign status.is_query   = (func_r == FUNC_QUERY);
  assign out_prefix_total  = total_r;

endmodule

// File: rtl/fenwick_prefix_sum_table.sv
// Fenwick prefix-sum table, top level: APB register, controller, datapath.
// An accepted word walks the tree node by node, one table RAM read per node in
// the table; a walk visits at most log2(depth)+1 nodes (11 at 1024). The next word
// is taken only once the walk is over and, for a query, its total is in the output
// register. After reset a clearing pass zeroes the table; no word is taken
// meanwhile, APB works.
module fenwick_prefix_sum_table
  import fpst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input words
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic [POS_W-1:0]          in_position,
  input  logic signed [DELTA_W-1:0] in_delta,
  // result words (queries only)
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SUM_W-1:0]   out_prefix_total,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0]     pwdata,
  output logic [CFG_DATA_W-1:0]     prdata,
  output logic                      pready
);

  fpst_cmd_t    cmd;
  fpst_status_t status;

  logic [POS_W-1:0] size_r;
  logic             wr_en;

  // Register map: word 0 (byte 0) is size_in_use; word 1 reads zero, writes ignored.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (wr_en) begin
      size_r <= pwdata[POS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SIZE_IN_USE) begin
      prdata = CFG_DATA_W'(size_r);
    end
  end

  // Controller owns the handshakes; the datapath only sees commands.
  fpst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: walk index, running total and the table RAM.
  fpst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .size_in_use      (size_r),
    .in_func          (in_func),
    .in_position      (in_position),
    .in_delta         (in_delta),
    .out_prefix_total (out_prefix_total)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking bench for fenwick_prefix_sum_table: point adds and prefix queries
// checked word by word against an in-bench tree model over several size settings.
// Depends on rtl/fpst_pkg.sv and rtl/fenwick_prefix_sum_table.sv.
`timescale 1ns / 1ps

module tb_top;
  import fpst_pkg::*;

  localparam int TREE_DEPTH      = DEPTH_DEFAULT;
  localparam int PHASES          = 7;
  localparam int WORDS_PER_PHASE = 90;
  localparam int PROBES          = 22;
  // long enough for an add touching 11 nodes to finish after it is taken; margin on top
  localparam int DRAIN_CYCLES    = 24;
  // output stall long enough to back the block up into its input
  localparam int LONG_HOLD       = 400;
  localparam logic [CFG_ADDR_W-1:0] SIZE_ADDR = {REG_SIZE_IN_USE, 2'b00};

  // one row of the opening table; total is used only when pinned is set
  typedef struct packed {
    logic                func;
    logic [POS_W-1:0]    pos;
    logic [DELTA_W-1:0]  delta;
    logic                pinned;
    logic [SUM_W-1:0]    total;
  } probe_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_func;
  logic [POS_W-1:0]          in_position;
  logic signed [DELTA_W-1:0] in_delta;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [SUM_W-1:0]   out_prefix_total;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_W-1:0]     paddr;
  logic [CFG_DATA_W-1:0]     pwdata;
  logic [CFG_DATA_W-1:0]     prdata;
  logic                      pready;

  // travels with the word on the input side: a hand-typed expected total
  logic                      word_pinned;
  logic [SUM_W-1:0]          word_pin_total;

  // bench copy of the tree, one-based like the block's indexing
  logic [SUM_W-1:0]          tree_sums [1:TREE_DEPTH];
  logic [POS_W-1:0]          size_limit;
  // prefix totals owed by the block, oldest first
  logic [SUM_W-1:0]          totals_due [$];

  int                        mismatch_count = 0;
  int                        tx_idle_pct = 0;
  int                        rx_stall_pct = 0;
  bit                        want_hold = 1'b0;

  fenwick_prefix_sum_table #(.TABLE_DEPTH(TREE_DEPTH)) u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; normal runs finish far earlier even with the clearing pass
  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Point add: sign-extend the delta, then climb by the lowest set bit
  // while the index stays within min(size, depth). Index zero never climbs.
  task automatic fold_in_add(logic [POS_W-1:0] pos, logic [DELTA_W-1:0] d);
    int               bound;
    int               idx;
    logic [SUM_W-1:0] amount;
    bound  = (size_limit > TREE_DEPTH) ? TREE_DEPTH : int'(size_limit);
    amount = {{(SUM_W-DELTA_W){d[DELTA_W-1]}}, d};
    idx    = int'(pos);
    if (idx != 0) begin
      while (idx <= bound) begin
        tree_sums[idx] = tree_sums[idx] + amount;
        idx = idx + (idx & -idx);
      end
    end
  endtask

  // Prefix query: strip the lowest set bit down to zero; nodes past the
  // table depth do not exist and add nothing. Wraps at 64 bits.
  function automatic logic [SUM_W-1:0] prefix_total_of(logic [POS_W-1:0] pos);
    int               idx;
    logic [SUM_W-1:0] acc;
    acc = '0;
    idx = int'(pos);
    while (idx > 0) begin
      if (idx <= TREE_DEPTH) acc = acc + tree_sums[idx];
      idx = idx - (idx & -idx);
    end
    return acc;
  endfunction

  function automatic probe_t probe_row(logic f, int pos, logic [DELTA_W-1:0] d,
                                       logic pin, logic [SUM_W-1:0] tot);
    probe_t r;
    r.func   = f;
    r.pos    = pos[POS_W-1:0];
    r.delta  = d;
    r.pinned = pin;
    r.total  = tot;
    return r;
  endfunction

  // Offer one word, after a random idle gap. Called at a rising edge and
  // returns at the edge where the word was taken, valid still high.
  task automatic send_word(logic f, logic [POS_W-1:0] pos, logic [DELTA_W-1:0] d,
                           logic pin, logic [SUM_W-1:0] tot);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_position    <= pos;
    in_delta       <= d;
    word_pinned    <= pin;
    word_pin_total <= tot;
    do @(posedge clk); while (!in_ready);
  endtask

  // write, then return the bus to idle before the next transfer
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // read back the size register; prdata is taken at the completing edge
  task automatic cfg_read_check(logic [CFG_ADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[POS_W-1:0] !== size_limit)
      flag_mismatch($sformatf("size readback %0d, expected %0d",
                              prdata[POS_W-1:0], size_limit));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every owed total has come back, then give a trailing add
  // time to finish its walk. The first edge lets the monitor log the last word.
  task automatic settle();
    @(posedge clk);
    while (totals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls per phase, plus one long hold on request.
  // The hold is counted here so the sender keeps pushing meanwhile.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Monitor. Values read right after the edge are the ones the block saw.
  // Results are handled first: a total leaving now can never belong to the
  // word that is entering at the same edge.
  always @(posedge clk) begin : watch
    logic [SUM_W-1:0] due;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (totals_due.size() == 0) begin
          flag_mismatch($sformatf("total %0d with no query pending", out_prefix_total));
        end else begin
          due = totals_due.pop_front();
          if (out_prefix_total !== due)
            flag_mismatch($sformatf("total %0d, expected %0d",
                                    out_prefix_total, $signed(due)));
        end
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_QUERY)
          totals_due = {totals_due,
                        (word_pinned ? word_pin_total : prefix_total_of(in_position))};
        else
          fold_in_add(in_position, in_delta);
      end
    end
  end

  initial begin : stimulus
    int                 sizes [PHASES];
    probe_t             probes [PROBES];
    probe_t             p;
    int                 k;
    int                 n;
    int                 bound;
    int                 pick;
    logic               f;
    logic [POS_W-1:0]   pos;
    logic [DELTA_W-1:0] d;

    // every input known from time zero
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_ADD;
    in_position    = '0;
    in_delta       = '0;
    word_pinned    = 1'b0;
    word_pin_total = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    size_limit     = SIZE_RESET;
    for (k = 1; k <= TREE_DEPTH; k++) tree_sums[k] = '0;

    // one full-size setting, one single-node tree, above depth, zero size,
    // two odd sizes, and back to the reset value
    sizes = '{1024, 1, 2047, 0, 37, 600, 1024};

    // Opening table, size at its reset value of 1024. Pinned totals are the
    // ones obvious by hand; the rest go to the tree model.
    probes[0]  = probe_row(FUNC_QUERY, 0,    '0,           1'b1, '0);  // empty prefix
    probes[1]  = probe_row(FUNC_QUERY, 1024, '0,           1'b1, '0);  // cleared table
    probes[2]  = probe_row(FUNC_QUERY, 2047, '0,           1'b1, '0);  // past the depth
    probes[3]  = probe_row(FUNC_ADD,   0,    32'h12345678, 1'b0, '0);  // add at zero: dropped
    probes[4]  = probe_row(FUNC_QUERY, 1,    '0,           1'b1, '0);
    probes[5]  = probe_row(FUNC_ADD,   1,    32'h7FFFFFFF, 1'b0, '0);  // longest climb
    probes[6]  = probe_row(FUNC_ADD,   1024, 32'h80000000, 1'b0, '0);  // top node only
    probes[7]  = probe_row(FUNC_QUERY, 1,    '0,           1'b1, 64'd2147483647);
    probes[8]  = probe_row(FUNC_QUERY, 1024, '0,           1'b1, -64'sd1);
    probes[9]  = probe_row(FUNC_ADD,   2047, 32'd100,      1'b0, '0);  // past the bound
    probes[10] = probe_row(FUNC_QUERY, 2047, '0,           1'b0, '0);
    probes[11] = probe_row(FUNC_ADD,   1023, 32'hFFFFFFFF, 1'b0, '0);
    probes[12] = probe_row(FUNC_QUERY, 1023, '0,           1'b0, '0);  // longest strip
    probes[13] = probe_row(FUNC_ADD,   1536, 32'd7,        1'b0, '0);  // past the bound
    probes[14] = probe_row(FUNC_QUERY, 1536, '0,           1'b0, '0);
    probes[15] = probe_row(FUNC_ADD,   682,  32'h55555555, 1'b0, '0);
    probes[16] = probe_row(FUNC_ADD,   1365, 32'hAAAAAAAA, 1'b0, '0);  // past the bound
    probes[17] = probe_row(FUNC_QUERY, 1365, '0,           1'b0, '0);
    probes[18] = probe_row(FUNC_QUERY, 682,  '0,           1'b0, '0);
    probes[19] = probe_row(FUNC_ADD,   512,  '0,           1'b0, '0);
    probes[20] = probe_row(FUNC_QUERY, 1000, '0,           1'b0, '0);
    probes[21] = probe_row(FUNC_QUERY, 2046, '0,           1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The block runs its clearing pass first; in_ready gates the first word.
    for (k = 0; k < PROBES; k++) begin
      p = probes[k];
      send_word(p.func, p.pos, p.delta, p.pinned, p.total);
    end
    in_valid <= 1'b0;
    settle();

    // Random phases: one size setting each, idling pattern rotating
    // through none / sender / receiver / both.
    for (k = 0; k < PHASES; k++) begin
      cfg_write(SIZE_ADDR, CFG_DATA_W'(sizes[k]));
      size_limit = POS_W'(sizes[k]);
      cfg_read_check(SIZE_ADDR);

      case (k % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 77;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 77;
        end
        default: begin
          tx_idle_pct  = 14;
          rx_stall_pct = 14;
        end
      endcase

      // back-pressure run: long output stall while words keep coming
      if (k == 4) begin
        @(negedge clk);
        want_hold = 1'b1;
        @(posedge clk);
      end

      bound = (sizes[k] > TREE_DEPTH) ? TREE_DEPTH : sizes[k];
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        f    = 1'($urandom_range(1));
        pick = $urandom_range(99);
        // mostly inside the bound; some zeros and some anywhere in the field
        if (pick < 10)
          pos = '0;
        else if (pick < 25 || bound == 0)
          pos = POS_W'($urandom_range(2047));
        else
          pos = POS_W'($urandom_range(bound, 1));
        pick = $urandom_range(99);
        if (pick < 4)
          d = 32'h7FFFFFFF;
        else if (pick < 8)
          d = 32'h80000000;
        else if (pick < 10)
          d = '1;
        else
          d = $urandom;
        send_word(f, pos, d, 1'b0, '0);
      end
      in_valid <= 1'b0;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
